// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the parser modules.
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ILP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ILP_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/ilp_pkg.sv =====
// ----------------------------------------------------------------------------
// ilp_pkg
// Types and constants shared by the integer literal parser modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ilp_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int OUT_WIDTH       = 32;
  localparam int CH_WIDTH        = 8;
  localparam int DIGIT_WIDTH     = 6;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [CH_WIDTH-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_WIDTH-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_WIDTH-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_WIDTH-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_WIDTH-1:0] CH_LOW_A = 8'h61;
  localparam logic [CH_WIDTH-1:0] CH_LOW_X = 8'h78;
  localparam logic [CH_WIDTH-1:0] CH_LOW_Z = 8'h7A;
  localparam logic [CH_WIDTH-1:0] CASE_BIT = 8'h20;

  localparam logic [DIGIT_WIDTH-1:0] BASE_DEC = 6'd10;
  localparam logic [DIGIT_WIDTH-1:0] BASE_OCT = 6'd8;
  localparam logic [DIGIT_WIDTH-1:0] BASE_HEX = 6'd16;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_HEX = 2'd2
  } radix_t;

  typedef enum logic [5:0] {
    PH_FIRST  = 6'b000001,
    PH_SIGNED = 6'b000010,
    PH_ZERO   = 6'b000100,
    PH_DIGITS = 6'b001000,
    PH_DONE   = 6'b010000,
    PH_FAIL   = 6'b100000
  } phase_t;

  // Classified character as it travels from front to back.
  typedef struct packed {
    logic                   last;
    logic                   nul;
    logic                   minus;
    logic                   zero;
    logic                   hex_x;
    logic                   alnum;
    logic [DIGIT_WIDTH-1:0] digit;
  } ilp_tok_t;

endpackage

// ===== rtl/ilp_channels.sv =====
// ----------------------------------------------------------------------------
// ilp_channels
// Valid/ready channels for characters in and parse results out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ilp_in_if;
  logic                          valid;
  logic                          ready;
  logic [ilp_pkg::CH_WIDTH-1:0]  ch;
  logic                          last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

interface ilp_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 ok;
  logic signed [ilp_pkg::OUT_WIDTH-1:0] value;

  modport source (output valid, output ok, output value, input ready);
  modport sink   (input valid, input ok, input value, output ready);
endinterface

// ===== rtl/ilp_front.sv =====
// ----------------------------------------------------------------------------
// ilp_front
// Accepts characters and classifies them into tokens for the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ilp_front (
  ilp_in_if.sink             in_ch,
  input  logic               q_full,
  output logic               push,
  output ilp_pkg::ilp_tok_t  tok
);

  logic [ilp_pkg::CH_WIDTH-1:0] lc;
  logic                         is_num;
  logic                         is_letter;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  assign lc        = in_ch.ch | ilp_pkg::CASE_BIT;
  assign is_num    = (in_ch.ch >= ilp_pkg::CH_ZERO) && (in_ch.ch <= ilp_pkg::CH_NINE);
  assign is_letter = (lc >= ilp_pkg::CH_LOW_A) && (lc <= ilp_pkg::CH_LOW_Z);

  always_comb begin
    tok.last  = in_ch.last;
    tok.nul   = (in_ch.ch == ilp_pkg::CH_NUL);
    tok.minus = (in_ch.ch == ilp_pkg::CH_MINUS);
    tok.zero  = (in_ch.ch == ilp_pkg::CH_ZERO);
    tok.hex_x = (lc == ilp_pkg::CH_LOW_X);
    tok.alnum = is_num || is_letter;
    if (is_num) begin
      tok.digit = ilp_pkg::DIGIT_WIDTH'(in_ch.ch - ilp_pkg::CH_ZERO);
    end else if (is_letter) begin
      tok.digit = ilp_pkg::DIGIT_WIDTH'(lc - ilp_pkg::CH_LOW_A) + ilp_pkg::BASE_DEC;
    end else begin
      tok.digit = '0;
    end
  end

endmodule

// ===== rtl/ilp_queue.sv =====
// ----------------------------------------------------------------------------
// ilp_queue
// Short token queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ilp_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ilp_pkg::ilp_tok_t  push_tok,
  output logic               full,
  input  logic               pop,
  output logic               tok_valid,
  output ilp_pkg::ilp_tok_t  tok
);

  localparam int DEPTH = ilp_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  ilp_pkg::ilp_tok_t  slot_r [DEPTH];
  logic [PW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]      count_r, count_nxt;

  assign full      = (count_r == CW'(DEPTH));
  assign tok_valid = (count_r != '0);
  assign tok       = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_tok;
    end
  end

  `ILP_NEVER(a_count_bound, count_r > CW'(DEPTH), "queue count beyond depth")
  `ILP_ASSERT(a_pop_ptr,
              (pop && !push && count_r == CW'(1)) |=> (rd_ptr_r == wr_ptr_r),
              "queue pointers disagree when drained")

endmodule

// ===== rtl/ilp_back.sv =====
// ----------------------------------------------------------------------------
// ilp_back
// Runs the parse state machine and accumulator, holds the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ilp_back #(
  parameter int VALUE_WIDTH = ilp_pkg::VALUE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               tok_valid,
  input  ilp_pkg::ilp_tok_t  tok,
  output logic               pop,
  ilp_out_if.source          out_res
);

  localparam int VW = VALUE_WIDTH;
  localparam int OW = ilp_pkg::OUT_WIDTH;
  localparam int DW = ilp_pkg::DIGIT_WIDTH;

  ilp_pkg::phase_t  phase_r, phase_nxt;
  ilp_pkg::radix_t  radix_r, radix_nxt;
  logic             neg_r, neg_nxt;
  logic [VW-1:0]    acc_r, acc_nxt;

  logic             out_valid_r;
  logic             ok_r;
  logic             res_neg_r;
  logic [VW-1:0]    mag_r;

  ilp_pkg::radix_t  use_radix;
  logic             do_digit;
  logic [DW-1:0]    base;
  logic [VW-1:0]    scaled;
  logic [VW-1:0]    acc_step;
  logic             slot_free;
  logic [VW-1:0]    signed_val;
  logic [VW+OW-1:0] ext_val;

  assign slot_free = !out_valid_r || out_res.ready;
  assign pop       = tok_valid && (!tok.last || slot_free);

  always_comb begin
    unique case (use_radix)
      ilp_pkg::RADIX_HEX: begin
        base   = ilp_pkg::BASE_HEX;
        scaled = acc_r << 4;
      end
      ilp_pkg::RADIX_OCT: begin
        base   = ilp_pkg::BASE_OCT;
        scaled = acc_r << 3;
      end
      default: begin
        base   = ilp_pkg::BASE_DEC;
        scaled = (acc_r << 3) + (acc_r << 1);
      end
    endcase
    acc_step = scaled + {{(VW-DW){1'b0}}, tok.digit};
  end

  always_comb begin
    phase_nxt = phase_r;
    radix_nxt = radix_r;
    neg_nxt   = neg_r;
    acc_nxt   = acc_r;
    use_radix = ilp_pkg::RADIX_DEC;
    do_digit  = 1'b0;
    unique case (phase_r)
      ilp_pkg::PH_FIRST, ilp_pkg::PH_SIGNED: begin
        if (phase_r == ilp_pkg::PH_FIRST && tok.minus) begin
          neg_nxt   = 1'b1;
          phase_nxt = tok.last ? ilp_pkg::PH_FAIL : ilp_pkg::PH_SIGNED;
        end else if (tok.zero) begin
          phase_nxt = ilp_pkg::PH_ZERO;
        end else begin
          phase_nxt = ilp_pkg::PH_DIGITS;
          do_digit  = 1'b1;
        end
      end
      ilp_pkg::PH_ZERO: begin
        if (tok.hex_x) begin
          radix_nxt = ilp_pkg::RADIX_HEX;
          phase_nxt = tok.last ? ilp_pkg::PH_FAIL : ilp_pkg::PH_DIGITS;
        end else if (tok.alnum && tok.digit < ilp_pkg::BASE_OCT) begin
          radix_nxt = ilp_pkg::RADIX_OCT;
          phase_nxt = ilp_pkg::PH_DIGITS;
          use_radix = ilp_pkg::RADIX_OCT;
          do_digit  = 1'b1;
        end else begin
          phase_nxt = ilp_pkg::PH_FAIL;
        end
      end
      ilp_pkg::PH_DIGITS: begin
        use_radix = radix_r;
        do_digit  = 1'b1;
      end
      default: begin
        // done or failed: drop characters until the last one
      end
    endcase
    if (do_digit) begin
      priority if (tok.nul) begin
        phase_nxt = ilp_pkg::PH_DONE;
      end else if (!tok.alnum || tok.digit >= base) begin
        phase_nxt = ilp_pkg::PH_FAIL;
      end else begin
        acc_nxt = acc_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= ilp_pkg::PH_FIRST;
      radix_r     <= ilp_pkg::RADIX_DEC;
      neg_r       <= 1'b0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        if (tok.last) begin
          phase_r <= ilp_pkg::PH_FIRST;
          radix_r <= ilp_pkg::RADIX_DEC;
          neg_r   <= 1'b0;
          acc_r   <= '0;
        end else begin
          phase_r <= phase_nxt;
          radix_r <= radix_nxt;
          neg_r   <= neg_nxt;
          acc_r   <= acc_nxt;
        end
      end
      if (pop && tok.last) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload; a failed request reports zero magnitude.
  always_ff @(posedge clk) begin
    if (pop && tok.last) begin
      ok_r      <= (phase_nxt != ilp_pkg::PH_FAIL);
      res_neg_r <= neg_nxt;
      mag_r     <= (phase_nxt != ilp_pkg::PH_FAIL) ? acc_nxt : '0;
    end
  end

  assign signed_val    = res_neg_r ? (~mag_r + VW'(1)) : mag_r;
  assign ext_val       = {{OW{1'b0}}, signed_val};
  assign out_res.valid = out_valid_r;
  assign out_res.ok    = ok_r;
  assign out_res.value = $signed(ext_val[OW-1:0]);

  `ILP_ASSERT(a_reset_after_result,
              (pop && tok.last) |=> (phase_r == ilp_pkg::PH_FIRST && !neg_r && acc_r == '0),
              "state not cleared after result")
  `ILP_ASSERT(a_fail_zero, (out_valid_r && !ok_r) |-> (mag_r == '0),
              "failed result carries a value")
  `ILP_ASSERT(a_lead_clean,
              (phase_r == ilp_pkg::PH_FIRST || phase_r == ilp_pkg::PH_SIGNED) |->
                (radix_r == ilp_pkg::RADIX_DEC && acc_r == '0),
              "digits gathered before the lead")

endmodule

// ===== rtl/integer_literal_parser_unit.sv =====
// ----------------------------------------------------------------------------
// integer_literal_parser_unit
// Streaming integer literal parser with automatic base selection.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one character per request (ch, last). The request marked
//   last closes the text and yields one result on out_res (ok, value);
//   other requests yield nothing. A leading minus negates, 0x/0X selects
//   hex, another leading 0 selects octal, else decimal. A NUL ends the
//   number, failing after a lone 0; later characters up to last are dropped.
//   Throughput: one character per cycle, sustained while no final character
//   waits for the result register. The front classifies a character in the
//   accept cycle and pushes it into a two-entry queue; the back pops one
//   token a cycle and does one multiply-add by shifts. The last character
//   passes the queue, then the result register, before out_res.valid rises.
//   Stall: a waiting result holds in the result register; the back keeps
//   popping non-final characters, and a final one waits in the queue until
//   the result register frees. Input ready drops only with the queue full.
//   Reset: synchronous active-low rst_n empties queue and result register
//   and returns the parser to expecting the first character.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module integer_literal_parser_unit #(
  parameter int VALUE_WIDTH = ilp_pkg::VALUE_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ilp_in_if.sink     in_ch,
  ilp_out_if.source  out_res
);

  ilp_pkg::ilp_tok_t front_tok;
  ilp_pkg::ilp_tok_t q_tok;
  logic              push;
  logic              q_full;
  logic              q_valid;
  logic              pop;

  ilp_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push),
    .tok    (front_tok)
  );

  ilp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_tok  (front_tok),
    .full      (q_full),
    .pop       (pop),
    .tok_valid (q_valid),
    .tok       (q_tok)
  );

  ilp_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (q_valid),
    .tok       (q_tok),
    .pop       (pop),
    .out_res   (out_res)
  );

endmodule
